>>> sv/stream_find_replace_defines.svh
// Assertion macros for the stream find-and-replace checker.
`ifndef STREAM_FIND_REPLACE_DEFINES_SVH
`define STREAM_FIND_REPLACE_DEFINES_SVH

// Check a consequence in the same cycle, outside reset.
`define SFR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stream_find_replace check failed");

// Check a consequence in the next cycle, outside reset.
`define SFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stream_find_replace check failed");

// Check a consequence in the cycle after reset is sampled.
`define SFR_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("stream_find_replace reset check failed");

`endif

>>> sv/sfr_pkg.sv
// Shared constants and types for the stream find-and-replace block.
package sfr_pkg;

  localparam int BYTE_W      = 8;
  localparam int PATTERN_MAX = 16;
  localparam int REPLACE_MAX = 16;
  localparam int RESULT_MAX  = 16;
  localparam int LEN_W       = 5;
  localparam int IDX_W       = 4;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int PAT_W       = PATTERN_MAX * BYTE_W;
  localparam int REP_W       = REPLACE_MAX * BYTE_W;

  localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_LEN  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_LOW  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PATTERN_HIGH = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_REPLACE_LEN  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_REPLACE_LOW  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_REPLACE_HIGH = 3'd5;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

>>> sv/sfr_cell.sv
// One window cell: holds a pending byte, shifts toward the head, compares to the pattern.
module sfr_cell (
  input  logic               clk,
  input  sfr_pkg::cell_ctl_t ctl,
  input  sfr_pkg::byte_t     load_byte,
  input  sfr_pkg::byte_t     nbr_byte,
  input  sfr_pkg::byte_t     pat_byte,
  input  sfr_pkg::byte_t     pat_prev_byte,
  output sfr_pkg::byte_t     cell_byte,
  output logic               eq,
  output logic               eq_prev
);

  sfr_pkg::byte_t byte_r;
  sfr_pkg::byte_t byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (ctl.load) begin
      byte_nxt = load_byte;
    end else if (ctl.shift) begin
      byte_nxt = nbr_byte;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign cell_byte = byte_r;
  assign eq        = (byte_r == pat_byte);
  assign eq_prev   = (byte_r == pat_prev_byte);

endmodule

>>> sv/stream_find_replace.sv
// Top level of the streaming find-and-replace block.
// Bytes enter on in_* with in_tlast on the final byte of a string; every leftmost,
// non-overlapping occurrence of the pattern (1..16 bytes) within the result budget
// leaves on out_* as the replacement (0..16 bytes). out_tuser is 0 only on an end
// marker that carries out_tlast when a string ends with no byte left to mark. Each
// byte waits in an input holding register until the block is ready and the output
// register can load. A non-final byte that neither completes a match nor finds more
// pending bytes than the pattern length is done as it is taken, so a string without
// matches streams at one byte per cycle while out_tready stays high. Any other byte
// enters the window, then emits its results (end marker included), with a decision
// step when it completes a match within the result budget, except for a final byte
// whose deleted match follows shifted-out bytes. While a byte is worked on, the
// next one waits in the holding register and in_tready drops; out_tready low stalls
// all of it. The earliest result of a byte shows on out_* after the edge that
// follows its input transaction. Write configuration through cfg_wen, cfg_addr and
// cfg_wdata only while no transaction is pending inside the block.
module stream_find_replace (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [sfr_pkg::BYTE_W-1:0]           in_tdata,   // [7:0] in_byte
  input  logic                                 in_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [sfr_pkg::BYTE_W-1:0]           out_tdata,  // [7:0] out_byte
  output logic                                 out_tuser,  // [0] out_valid
  output logic                                 out_tlast,
  input  logic                                 cfg_wen,
  input  logic [sfr_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  typedef enum logic [1:0] {S_ACC, S_RUN, S_REP} state_t;

  localparam int NC = sfr_pkg::PATTERN_MAX;
  localparam logic [sfr_pkg::LEN_W-1:0] PLEN_MAX = sfr_pkg::LEN_W'(sfr_pkg::PATTERN_MAX);
  localparam logic [sfr_pkg::LEN_W-1:0] RLEN_MAX = sfr_pkg::LEN_W'(sfr_pkg::REPLACE_MAX);

  // configuration
  logic [sfr_pkg::LEN_W-1:0] plen_r;
  logic [sfr_pkg::LEN_W-1:0] rlen_r;
  logic [sfr_pkg::PAT_W-1:0] pat_r;
  logic [sfr_pkg::REP_W-1:0] rep_r;
  logic [sfr_pkg::LEN_W-1:0] wr_len;

  assign wr_len = cfg_wdata[sfr_pkg::LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r <= sfr_pkg::LEN_W'(1);
      rlen_r <= '0;
      pat_r  <= '0;
      rep_r  <= '0;
    end else if (cfg_wen) begin
      case (cfg_addr)
        sfr_pkg::REG_PATTERN_LEN: begin
          if (wr_len == '0) begin
            plen_r <= sfr_pkg::LEN_W'(1);
          end else if (wr_len > PLEN_MAX) begin
            plen_r <= PLEN_MAX;
          end else begin
            plen_r <= wr_len;
          end
        end
        sfr_pkg::REG_PATTERN_LOW:  pat_r[sfr_pkg::PAT_W/2-1:0] <= cfg_wdata;
        sfr_pkg::REG_PATTERN_HIGH: pat_r[sfr_pkg::PAT_W-1:sfr_pkg::PAT_W/2] <= cfg_wdata;
        sfr_pkg::REG_REPLACE_LEN: begin
          rlen_r <= (wr_len > RLEN_MAX) ? RLEN_MAX : wr_len;
        end
        sfr_pkg::REG_REPLACE_LOW:  rep_r[sfr_pkg::REP_W/2-1:0] <= cfg_wdata;
        sfr_pkg::REG_REPLACE_HIGH: rep_r[sfr_pkg::REP_W-1:sfr_pkg::REP_W/2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // control and output registers
  state_t                      state_r, state_nxt;
  logic [sfr_pkg::LEN_W-1:0]   count_r, count_nxt;
  logic [sfr_pkg::LEN_W-1:0]   n_r, n_nxt;
  logic [sfr_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic                        last_r, last_nxt;
  logic                        hold_v_r, hold_v_nxt;
  sfr_pkg::byte_t              hold_byte_r, hold_byte_nxt;
  logic                        hold_last_r, hold_last_nxt;
  logic                        out_tvalid_r, out_tvalid_nxt;
  sfr_pkg::byte_t              out_byte_r, out_byte_nxt;
  logic                        out_vflag_r, out_vflag_nxt;
  logic                        out_last_r, out_last_nxt;

  // window cells
  sfr_pkg::byte_t              win [NC];
  sfr_pkg::byte_t              nbr [NC];
  sfr_pkg::byte_t              pprev [NC];
  logic [NC-1:0]               eq;
  logic [NC-1:0]               eqp;
  sfr_pkg::cell_ctl_t          cell_ctl [NC];
  logic                        cell_shift;
  logic [NC-1:0]               cell_load;

  logic [NC-1:0]               plen_mask;
  logic [NC-1:0]               cnt_mask;
  logic [NC-1:0]               shm_mask;
  logic                        full_match;
  logic                        shift_match;
  logic                        fast_match;
  logic                        budget_ok;
  logic [sfr_pkg::LEN_W-1:0]   cnt1;
  logic [sfr_pkg::IDX_W-1:0]   cnt_m1;
  sfr_pkg::byte_t              pat_at_cnt;
  sfr_pkg::byte_t              rep_byte;
  logic                        can_emit;
  logic                        take;
  logic                        in_accept;
  logic                        emit;
  sfr_pkg::byte_t              em_byte;
  logic                        em_vflag;
  logic                        em_last;

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      nbr[i]       = (i == NC - 1) ? '0 : win[(i + 1) % NC];
      pprev[i]     = (i == 0) ? '0 : pat_r[((i + NC - 1) % NC) * sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W];
      plen_mask[i] = (sfr_pkg::LEN_W'(i) < plen_r);
      cnt_mask[i]  = (sfr_pkg::LEN_W'(i) < count_r);
      shm_mask[i]  = (i != 0) && (sfr_pkg::LEN_W'(i) <= plen_r);
      cell_ctl[i].shift = cell_shift;
      cell_ctl[i].load  = cell_load[i];
    end
  end

  for (genvar gi = 0; gi < NC; gi++) begin : g_cell
    sfr_cell u_cell (
      .clk           (clk),
      .ctl           (cell_ctl[gi]),
      .load_byte     (hold_byte_r),
      .nbr_byte      (nbr[gi]),
      .pat_byte      (pat_r[gi*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W]),
      .pat_prev_byte (pprev[gi]),
      .cell_byte     (win[gi]),
      .eq            (eq[gi]),
      .eq_prev       (eqp[gi])
    );
  end

  assign cnt1        = count_r + sfr_pkg::LEN_W'(1);
  assign cnt_m1      = count_r[sfr_pkg::IDX_W-1:0] - sfr_pkg::IDX_W'(1);
  assign pat_at_cnt  = pat_r[{count_r[sfr_pkg::IDX_W-1:0], 3'b000} +: sfr_pkg::BYTE_W];
  assign rep_byte    = rep_r[{idx_r, 3'b000} +: sfr_pkg::BYTE_W];
  assign full_match  = &(eq | ~plen_mask);
  assign shift_match = &(eqp | ~shm_mask);
  assign fast_match  = (&(eq | ~cnt_mask)) && (hold_byte_r == pat_at_cnt);
  assign budget_ok   = ({1'b0, n_r} + {1'b0, rlen_r}) <= (sfr_pkg::LEN_W+1)'(sfr_pkg::RESULT_MAX);

  assign can_emit  = !out_tvalid_r || out_tready;
  assign in_tready = !hold_v_r || take;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    emit       = 1'b0;
    em_byte    = win[0];
    em_vflag   = 1'b1;
    em_last    = 1'b0;
    cell_shift = 1'b0;
    cell_load  = '0;
    count_nxt  = count_r;
    state_nxt  = state_r;
    n_nxt      = n_r;
    idx_nxt    = idx_r;
    last_nxt   = last_r;
    take       = 1'b0;
    case (state_r)
      S_ACC: begin
        if (hold_v_r && can_emit) begin
          take = 1'b1;
          if (!hold_last_r && (cnt1 < plen_r)) begin
            cell_load[count_r[sfr_pkg::IDX_W-1:0]] = 1'b1;
            count_nxt = cnt1;
          end else if (!hold_last_r && (cnt1 == plen_r) && !fast_match) begin
            // append and drop the oldest byte in one step
            emit       = 1'b1;
            em_byte    = (count_r == '0) ? hold_byte_r : win[0];
            cell_shift = 1'b1;
            if (count_r != '0) begin
              cell_load[cnt_m1] = 1'b1;
            end
          end else begin
            cell_load[count_r[sfr_pkg::IDX_W-1:0]] = 1'b1;
            count_nxt = cnt1;
            n_nxt     = '0;
            last_nxt  = hold_last_r;
            state_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (can_emit) begin
          if (count_r > plen_r) begin
            emit       = 1'b1;
            cell_shift = 1'b1;
            n_nxt      = n_r + sfr_pkg::LEN_W'(1);
            if (last_r && (rlen_r == '0) && (count_r == plen_r + sfr_pkg::LEN_W'(1))
                && shift_match) begin
              em_last   = 1'b1;
              count_nxt = '0;
              state_nxt = S_ACC;
            end else begin
              count_nxt = count_r - sfr_pkg::LEN_W'(1);
            end
          end else if ((count_r == plen_r) && full_match && budget_ok) begin
            count_nxt = '0;
            idx_nxt   = '0;
            if (rlen_r == '0) begin
              state_nxt = last_r ? S_RUN : S_ACC;
            end else begin
              state_nxt = S_REP;
            end
          end else if ((count_r != '0) && ((count_r == plen_r) || last_r)) begin
            emit       = 1'b1;
            cell_shift = 1'b1;
            n_nxt      = n_r + sfr_pkg::LEN_W'(1);
            if (last_r && (count_r == sfr_pkg::LEN_W'(1))) begin
              em_last   = 1'b1;
              count_nxt = '0;
              state_nxt = S_ACC;
            end else begin
              count_nxt = count_r - sfr_pkg::LEN_W'(1);
              state_nxt = last_r ? S_RUN : S_ACC;
            end
          end else if (last_r && (count_r == '0) && (n_r == '0)) begin
            emit      = 1'b1;
            em_byte   = '0;
            em_vflag  = 1'b0;
            em_last   = 1'b1;
            state_nxt = S_ACC;
          end else begin
            state_nxt = S_ACC;
          end
        end
      end
      S_REP: begin
        if (can_emit) begin
          emit    = 1'b1;
          em_byte = rep_byte;
          if ({1'b0, idx_r} + sfr_pkg::LEN_W'(1) == rlen_r) begin
            em_last   = last_r;
            state_nxt = S_ACC;
          end else begin
            idx_nxt = idx_r + sfr_pkg::IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_ACC;
      end
    endcase
  end

  always_comb begin
    hold_v_nxt    = hold_v_r;
    hold_byte_nxt = hold_byte_r;
    hold_last_nxt = hold_last_r;
    if (in_accept) begin
      hold_v_nxt    = 1'b1;
      hold_byte_nxt = in_tdata;
      hold_last_nxt = in_tlast;
    end else if (take) begin
      hold_v_nxt = 1'b0;
    end
    out_tvalid_nxt = can_emit ? emit : out_tvalid_r;
    out_byte_nxt   = out_byte_r;
    out_vflag_nxt  = out_vflag_r;
    out_last_nxt   = out_last_r;
    if (can_emit && emit) begin
      out_byte_nxt  = em_byte;
      out_vflag_nxt = em_vflag;
      out_last_nxt  = em_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_ACC;
      count_r      <= '0;
      hold_v_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      hold_v_r     <= hold_v_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    n_r         <= n_nxt;
    idx_r       <= idx_nxt;
    last_r      <= last_nxt;
    hold_byte_r <= hold_byte_nxt;
    hold_last_r <= hold_last_nxt;
    out_byte_r  <= out_byte_nxt;
    out_vflag_r <= out_vflag_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_vflag_r;
  assign out_tlast  = out_last_r;

endmodule

>>> sv/sfr_chk.sv
// Port-level checker for the stream find-and-replace block, with its bind.
`include "stream_find_replace_defines.svh"

module sfr_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [sfr_pkg::BYTE_W-1:0]  out_tdata,
  input logic                        out_tuser,
  input logic                        out_tlast
);

  `SFR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `SFR_ASSERT_NOW(a_marker_last, out_tvalid && !out_tuser, out_tlast)
  `SFR_ASSERT_NOW(a_marker_zero, out_tvalid && !out_tuser, out_tdata == '0)
  `SFR_ASSERT_RST(a_reset_idle, !out_tvalid)

endmodule

bind stream_find_replace sfr_chk u_sfr_chk (.*);

>>> dv/tb_stream_find_replace.sv
// Testbench for stream_find_replace: byte-stream find-and-replace checked against a predictor.
`timescale 1ns / 100ps

module tb_stream_find_replace;
  import sfr_pkg::*;

  localparam int ITEM_TARGET   = 385;
  localparam int CALM_ITEMS    = 60;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 20;
  localparam int LONG_HOLD     = 300;
  localparam int CYCLE_LIMIT   = 600000;

  typedef struct packed {
    byte_t data;
    logic  valid;
    logic  last;
  } out_item_t;

  class find_replace_scoreboard;
    byte_t                 window_q[$];
    logic [LEN_W-1:0]      pat_len_reg = 5'd1;
    logic [LEN_W-1:0]      rep_len_reg = 5'd0;
    logic [CFG_DATA_W-1:0] pat_lo = '0, pat_hi = '0, rep_lo = '0, rep_hi = '0;
    out_item_t             expected_q[$];
    int                    errors = 0, checked = 0, replacements = 0;

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_PATTERN_LEN:  pat_len_reg = val[LEN_W-1:0];
        REG_PATTERN_LOW:  pat_lo = val;
        REG_PATTERN_HIGH: pat_hi = val;
        REG_REPLACE_LEN:  rep_len_reg = val[LEN_W-1:0];
        REG_REPLACE_LOW:  rep_lo = val;
        REG_REPLACE_HIGH: rep_hi = val;
        default: ;
      endcase
    endfunction

    function byte_t pick(logic [CFG_DATA_W-1:0] lo, logic [CFG_DATA_W-1:0] hi, int k);
      logic [CFG_DATA_W-1:0] w;
      w = (k < 8) ? lo : hi;
      return w[8*(k%8) +: 8];
    endfunction

    function void note_input(byte_t b, logic last);
      int        plen, rlen, k;
      logic      hit;
      out_item_t step_q[$];
      plen = int'(pat_len_reg);
      rlen = int'(rep_len_reg);
      if (plen == 0) plen = 1;
      if (plen > PATTERN_MAX) plen = PATTERN_MAX;
      if (rlen > REPLACE_MAX) rlen = REPLACE_MAX;
      if (window_q.size() >= PATTERN_MAX) step_q.push_back('{window_q.pop_front(), 1'b1, 1'b0});
      window_q.push_back(b);
      while (window_q.size() > plen) step_q.push_back('{window_q.pop_front(), 1'b1, 1'b0});
      if (window_q.size() == plen) begin
        hit = 1'b1;
        for (k = 0; k < plen; k++)
          if (window_q[k] != pick(pat_lo, pat_hi, k)) hit = 1'b0;
        if (hit && step_q.size() + rlen <= RESULT_MAX) begin
          for (k = 0; k < rlen; k++) step_q.push_back('{pick(rep_lo, rep_hi, k), 1'b1, 1'b0});
          window_q.delete();
          replacements++;
        end else begin
          step_q.push_back('{window_q.pop_front(), 1'b1, 1'b0});
        end
      end
      if (last) begin
        while (window_q.size() > 0 && step_q.size() < RESULT_MAX)
          step_q.push_back('{window_q.pop_front(), 1'b1, 1'b0});
        window_q.delete();
        if (step_q.size() == 0) step_q.push_back('{8'h00, 1'b0, 1'b0});
        step_q[step_q.size()-1].last = 1'b1;
      end
      foreach (step_q[i]) expected_q.push_back(step_q[i]);
    endfunction

    function void check_result(byte_t data, logic valid, logic last);
      out_item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, actual tdata=%02h tuser=%b tlast=%b",
                 $time, data, valid, last);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (want.data !== data) begin
        errors++;
        $display("%0t: out_tdata expected %02h, actual %02h", $time, want.data, data);
      end
      if (want.valid !== valid) begin
        errors++;
        $display("%0t: out_tuser expected %b, actual %b", $time, want.valid, valid);
      end
      if (want.last !== last) begin
        errors++;
        $display("%0t: out_tlast expected %b, actual %b", $time, want.last, last);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [BYTE_W-1:0]     out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_wen = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  find_replace_scoreboard sb = new();

  int         cycles = 0;
  int         accepted_items = 0;
  int         settings_used = 0;
  int         hold_reqs = 0;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  bit         calm = 1'b0;
  int         cur_plen = 1;
  logic [PAT_W-1:0] cur_pat = '0;
  byte_t      sym_a, sym_b;

  stream_find_replace uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int stall_left, hold_left, holds_seen;
    stall_left = 0;
    hold_left  = 0;
    holds_seen = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
      @(negedge clk);
      if (holds_seen != hold_reqs) begin
        holds_seen = hold_reqs;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < rx_idle_pct) begin
        stall_left = $urandom_range(0, 13);
        out_tready = 1'b0;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  task automatic send_byte(byte_t b, logic last);
    if (!calm && $urandom_range(0, 99) < tx_idle_pct) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 13)) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tlast  = last;
    do @(posedge clk); while (!in_tready);
    sb.note_input(b, last);
    accepted_items++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wen   = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  function automatic logic [CFG_DATA_W-1:0] len_word(int raw);
    logic [CFG_DATA_W-1:0] val;
    val = {$urandom, $urandom};
    if ($urandom_range(0, 1)) val = '0;
    val[LEN_W-1:0] = raw[LEN_W-1:0];
    return val;
  endfunction

  task automatic program_block(int plen_raw, logic [PAT_W-1:0] pat,
                               int rlen_raw, logic [REP_W-1:0] rep);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_PATTERN_LEN,  len_word(plen_raw));
    write_reg(REG_PATTERN_LOW,  pat[63:0]);
    write_reg(REG_PATTERN_HIGH, pat[127:64]);
    write_reg(REG_REPLACE_LEN,  len_word(rlen_raw));
    write_reg(REG_REPLACE_LOW,  rep[63:0]);
    write_reg(REG_REPLACE_HIGH, rep[127:64]);
    @(negedge clk);
    cfg_wen = 1'b0;
    cur_pat  = pat;
    cur_plen = (plen_raw == 0) ? 1 : (plen_raw > PATTERN_MAX) ? PATTERN_MAX : plen_raw;
    settings_used++;
  endtask

  task automatic send_string(int len, bit terminate);
    byte_t s[$];
    int    k;
    while (s.size() < len) begin
      if ($urandom_range(0, 3) == 0) begin
        for (k = 0; k < cur_plen; k++) s.push_back(cur_pat[8*k +: 8]);
      end else if ($urandom_range(0, 1)) begin
        s.push_back($urandom_range(0, 1) ? sym_a : sym_b);
      end else begin
        s.push_back(8'($urandom_range(0, 255)));
      end
    end
    foreach (s[i]) send_byte(s[i], terminate && (i == s.size() - 1));
  endtask

  function automatic logic [PAT_W-1:0] random_wide(bit from_symbols);
    logic [PAT_W-1:0] w;
    for (int k = 0; k < PATTERN_MAX; k++)
      w[8*k +: 8] = from_symbols ? ($urandom_range(0, 1) ? sym_a : sym_b)
                                 : 8'($urandom_range(0, 255));
    return w;
  endfunction

  initial begin
    logic [PAT_W-1:0] pat;
    int               phase, plen_raw, rlen_raw, strings;
    bit               terminate;

    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: single zero byte deleted, empty end marker.
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b1);

    sym_a = 8'hff;
    sym_b = 8'h00;
    program_block(0, {120'h0, 8'hff}, 17, random_wide(1'b0));
    send_byte(8'hff, 1'b0);
    send_byte(8'h7f, 1'b1);

    pat = random_wide(1'b0);
    program_block(31, pat, 2, random_wide(1'b0));
    for (int k = 0; k < PATTERN_MAX - 1; k++) send_byte(pat[8*k +: 8], 1'b0);
    program_block(1, {pat[127:8], 8'h5a}, 2, random_wide(1'b0));
    send_byte(8'h5a, 1'b0);
    send_byte(8'ha5, 1'b1);

    phase = 0;
    while (accepted_items < ITEM_TARGET) begin
      phase++;
      calm  = (accepted_items >= ITEM_TARGET - CALM_ITEMS);
      sym_a = 8'($urandom_range(0, 255));
      sym_b = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
        0:       plen_raw = PATTERN_MAX;
        1:       plen_raw = $urandom_range(0, 1) ? 0 : $urandom_range(17, 31);
        2:       plen_raw = $urandom_range(7, 15);
        default: plen_raw = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 7))
        0:       rlen_raw = 0;
        1:       rlen_raw = REPLACE_MAX;
        2:       rlen_raw = $urandom_range(17, 31);
        default: rlen_raw = $urandom_range(0, 6);
      endcase
      program_block(plen_raw, random_wide($urandom_range(0, 1)), rlen_raw, random_wide(1'b0));
      tx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 25);
      rx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 25);
      strings = $urandom_range(1, 4);
      if (phase % 12 == 3 && !calm) begin
        tx_idle_pct = 0;
        hold_reqs++;
        send_string(60, 1'b1);
      end
      for (int j = 0; j < strings; j++) begin
        terminate = (j < strings - 1) || calm || ($urandom_range(0, 3) != 0);
        send_string($urandom_range(0, 5) == 0 ? 40 : $urandom_range(1, 16), terminate);
        if (phase % 12 == 7 && j == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d input bytes across %0d register settings; %0d output transactions checked,",
             accepted_items, settings_used, sb.checked);
    $display("%0d pattern replacements predicted, %0d mismatches.", sb.replacements, sb.errors);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/sfr_pkg.sv
sv/sfr_cell.sv
sv/stream_find_replace.sv
sv/sfr_chk.sv
dv/tb_stream_find_replace.sv
